/* hw/rtl/wbs_pkg.sv */
// Package for the windowed bucket statistics block.
// Holds widths, reset values, saturation limits and the bucket record type.
// No dependencies.
package wbs_pkg;

	localparam int unsigned MAX_BUCKETS = 16;
	localparam int unsigned IDX_W       = $clog2(MAX_BUCKETS);
	localparam int unsigned LIVE_W      = $clog2(MAX_BUCKETS + 1);
	localparam int unsigned DIV_STEPS   = 58;
	localparam int unsigned DSTEP_W     = $clog2(DIV_STEPS);

	localparam logic [15:0] WINDOW_RESET = 16'd1000;
	localparam logic [15:0] BUCKET_RESET = 16'd100;

	localparam logic [47:0] TOT_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] TOT_MIN = 48'h8000_0000_0000;
	localparam logic [23:0] CNT_MAX = 24'hFF_FFFF;
	localparam logic [39:0] AVG_MAX = 40'h7F_FFFF_FFFF;
	localparam logic [39:0] AVG_MIN = 40'h80_0000_0000;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_DUMP  = 2'd2;

	localparam logic REG_WINDOW = 1'b0;

	typedef struct packed {
		logic [31:0]        start;
		logic signed [47:0] total;
		logic [23:0]        count;
		logic signed [31:0] mn;
		logic signed [31:0] mx;
	} bkt_t;

	typedef struct packed {
		logic signed [31:0] mn;
		logic signed [31:0] mx;
		logic signed [47:0] total;
		logic [23:0]        count;
		logic signed [39:0] avg;
	} res_t;

endpackage

/* hw/rtl/windowed_bucket_stats_top.sv */
// Top level of the windowed bucket statistics block.
// Depends on wbs_pkg for types and constants.
//
// Keeps a ring of 16 time buckets and answers add, query and dump commands.
// A command is taken when start is high and busy is low; busy stays high until
// the last result has been presented. Results appear for exactly one cycle
// with done high; the receiver cannot stall them, so it must capture every
// transfer. An add first retires every bucket that has aged out of the
// window. A query walks the buckets and then runs up to two serial
// divides (average, then rate). A dump walks the live buckets and runs
// one divide for each bucket it reports. The single radix-2 divider,
// one quotient bit per cycle, serves all of them.
// Registers: window_ms at byte address 0, bucket_ms at byte address 4.
module windowed_bucket_stats_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic [31:0]        now_ms,
	input  logic signed [31:0] sample,
	input  logic [15:0]        span_ms,
	output logic               done,
	output logic signed [31:0] min_value,
	output logic signed [31:0] max_value,
	output logic signed [47:0] total,
	output logic [23:0]        sample_count,
	output logic signed [39:0] average_q8,
	output logic signed [57:0] rate_per_second,
	output logic               last
);

	typedef enum logic [3:0] {
		S_IDLE, S_A_RD, S_A_CHK, S_A_RDN, S_A_MRG,
		S_Q_RD, S_Q_ACC, S_D_RD, S_D_CHK,
		S_AVG, S_AVG_W, S_RATE, S_RATE_W, S_FIN
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0] window_q, bucket_q;

	// Bucket ring, read through a single registered port.
	wbs_pkg::bkt_t                    ring_q [wbs_pkg::MAX_BUCKETS];
	wbs_pkg::bkt_t                    rd_q;
	logic [wbs_pkg::IDX_W-1:0]        oldest_q;
	logic [wbs_pkg::LIVE_W-1:0]       live_q;
	logic [wbs_pkg::LIVE_W-1:0]       k_q;

	// Latched command.
	logic [1:0]         cmd_q;
	logic [31:0]        now_q;
	logic signed [31:0] smp_q;
	logic [15:0]        span_q;

	// Accumulators for a query, or the current bucket for a dump.
	logic signed [31:0] acc_mn_q, acc_mx_q;
	logic signed [47:0] acc_tot_q;
	logic [23:0]        acc_cnt_q;
	logic               any_q;
	logic signed [39:0] avg_q;

	// Dump results wait here until the next one shows whether they are last.
	wbs_pkg::res_t pend_q;
	logic          pend_vld_q;

	// Serial divider: the dividend register shifts out on top, quotient bits in below.
	logic [57:0] dv_num_q;
	logic [23:0] dv_den_q;
	logic [23:0] dv_rem_q;
	logic [wbs_pkg::DSTEP_W-1:0] dv_cnt_q;

	// Output registers.
	wbs_pkg::res_t      out_q;
	logic signed [57:0] rate_q;
	logic               done_q, last_q;

	logic [24:0] dv_shift;
	logic        dv_ge;
	logic [23:0] dv_rem_n;
	logic [57:0] dv_num_n;
	logic [31:0] age;
	logic [wbs_pkg::IDX_W-1:0] newest_idx, walk_idx, dump_idx, new_idx;
	logic [48:0] mrg_sum, acc_sum;
	logic [47:0] mrg_tot, acc_tot_n;
	logic [24:0] acc_cnt_sum;
	logic [23:0] acc_cnt_n;
	logic [47:0] tot_abs;
	logic [57:0] rate_dividend;
	logic        cfg_wr;
	wbs_pkg::res_t cur_res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == wbs_pkg::REG_WINDOW) ? {16'd0, window_q} : {16'd0, bucket_q};

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign last            = last_q;
	assign min_value       = out_q.mn;
	assign max_value       = out_q.mx;
	assign total           = out_q.total;
	assign sample_count    = out_q.count;
	assign average_q8      = out_q.avg;
	assign rate_per_second = rate_q;

	always_comb begin
		age        = now_q - rd_q.start;
		newest_idx = oldest_q + wbs_pkg::IDX_W'(live_q - 1'b1);
		walk_idx   = oldest_q + wbs_pkg::IDX_W'(k_q - 1'b1);
		dump_idx   = oldest_q + k_q[wbs_pkg::IDX_W-1:0];
		new_idx    = oldest_q + live_q[wbs_pkg::IDX_W-1:0];

		// Sample merged into a bucket total, clamped to 48 bits.
		mrg_sum = {rd_q.total[47], rd_q.total} + {{17{smp_q[31]}}, smp_q};
		if (mrg_sum[48] != mrg_sum[47])
			mrg_tot = mrg_sum[48] ? wbs_pkg::TOT_MIN : wbs_pkg::TOT_MAX;
		else
			mrg_tot = mrg_sum[47:0];

		// Bucket total added into the query sum, clamped to 48 bits.
		acc_sum = {acc_tot_q[47], acc_tot_q} + {rd_q.total[47], rd_q.total};
		if (acc_sum[48] != acc_sum[47])
			acc_tot_n = acc_sum[48] ? wbs_pkg::TOT_MIN : wbs_pkg::TOT_MAX;
		else
			acc_tot_n = acc_sum[47:0];
		acc_cnt_sum = {1'b0, acc_cnt_q} + {1'b0, rd_q.count};
		acc_cnt_n   = acc_cnt_sum[24] ? wbs_pkg::CNT_MAX : acc_cnt_sum[23:0];

		tot_abs       = acc_tot_q[47] ? 48'(-acc_tot_q) : acc_tot_q;
		rate_dividend = ({10'd0, tot_abs} << 10) - ({10'd0, tot_abs} << 4)
			- ({10'd0, tot_abs} << 3);

		// One restoring divide step.
		dv_shift = {dv_rem_q, dv_num_q[57]};
		dv_ge    = (dv_shift >= {1'b0, dv_den_q});
		dv_rem_n = dv_ge ? 24'(dv_shift - {1'b0, dv_den_q}) : dv_shift[23:0];
		dv_num_n = {dv_num_q[56:0], dv_ge};

		cur_res.mn    = acc_mn_q;
		cur_res.mx    = acc_mx_q;
		cur_res.total = acc_tot_q;
		cur_res.count = acc_cnt_q;
		cur_res.avg   = avg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= wbs_pkg::WINDOW_RESET;
			bucket_q <= wbs_pkg::BUCKET_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == wbs_pkg::REG_WINDOW)
				window_q <= pwdata[15:0];
			else
				bucket_q <= pwdata[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			oldest_q   <= '0;
			live_q     <= '0;
			k_q        <= '0;
			pend_vld_q <= 1'b0;
			done_q     <= 1'b0;
			last_q     <= 1'b0;
			any_q      <= 1'b0;
			dv_cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q  <= cmd;
						now_q  <= now_ms;
						smp_q  <= sample;
						span_q <= (span_ms > window_q) ? window_q : span_ms;
						any_q      <= 1'b0;
						acc_mn_q   <= '0;
						acc_mx_q   <= '0;
						acc_tot_q  <= '0;
						acc_cnt_q  <= '0;
						pend_vld_q <= 1'b0;
						if (cmd == wbs_pkg::CMD_ADD) begin
							state_q <= S_A_RD;
						end else if (cmd == wbs_pkg::CMD_QUERY) begin
							k_q     <= live_q;
							state_q <= S_Q_RD;
						end else if (cmd == wbs_pkg::CMD_DUMP) begin
							k_q     <= '0;
							state_q <= S_D_RD;
						end
					end
				end
				S_A_RD: begin
					rd_q    <= ring_q[oldest_q];
					state_q <= S_A_CHK;
				end
				S_A_CHK: begin
					if (live_q != '0 && age > {16'd0, window_q}) begin
						oldest_q <= oldest_q + 1'b1;
						live_q   <= live_q - 1'b1;
						state_q  <= S_A_RD;
					end else if (live_q != '0) begin
						state_q <= S_A_RDN;
					end else begin
						ring_q[new_idx] <= '{start: now_q, total: 48'(smp_q),
							count: 24'd1, mn: smp_q, mx: smp_q};
						live_q  <= live_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_A_RDN: begin
					rd_q    <= ring_q[newest_idx];
					state_q <= S_A_MRG;
				end
				S_A_MRG: begin
					if (age < {16'd0, bucket_q}) begin
						ring_q[newest_idx].total <= mrg_tot;
						ring_q[newest_idx].count <= (rd_q.count == wbs_pkg::CNT_MAX) ?
							wbs_pkg::CNT_MAX : rd_q.count + 24'd1;
						if (smp_q < rd_q.mn)
							ring_q[newest_idx].mn <= smp_q;
						if (smp_q > rd_q.mx)
							ring_q[newest_idx].mx <= smp_q;
					end else begin
						ring_q[new_idx] <= '{start: now_q, total: 48'(smp_q),
							count: 24'd1, mn: smp_q, mx: smp_q};
						if (live_q == wbs_pkg::LIVE_W'(wbs_pkg::MAX_BUCKETS))
							oldest_q <= oldest_q + 1'b1;
						else
							live_q <= live_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_Q_RD: begin
					rd_q <= ring_q[walk_idx];
					state_q <= (k_q == '0) ? S_AVG : S_Q_ACC;
				end
				S_Q_ACC: begin
					if (age > {16'd0, span_q}) begin
						state_q <= S_AVG;
					end else begin
						acc_mn_q  <= (!any_q || rd_q.mn < acc_mn_q) ? rd_q.mn : acc_mn_q;
						acc_mx_q  <= (!any_q || rd_q.mx > acc_mx_q) ? rd_q.mx : acc_mx_q;
						acc_tot_q <= acc_tot_n;
						acc_cnt_q <= acc_cnt_n;
						any_q     <= 1'b1;
						k_q       <= k_q - 1'b1;
						state_q   <= S_Q_RD;
					end
				end
				S_D_RD: begin
					if (k_q == live_q) begin
						done_q <= 1'b1;
						last_q <= 1'b1;
						rate_q <= '0;
						out_q  <= pend_vld_q ? pend_q : '0;
						state_q <= S_IDLE;
					end else begin
						rd_q    <= ring_q[dump_idx];
						state_q <= S_D_CHK;
					end
				end
				S_D_CHK: begin
					if (age > {16'd0, window_q}) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_D_RD;
					end else begin
						acc_mn_q  <= rd_q.mn;
						acc_mx_q  <= rd_q.mx;
						acc_tot_q <= rd_q.total;
						acc_cnt_q <= rd_q.count;
						state_q   <= S_AVG;
					end
				end
				S_AVG: begin
					avg_q <= '0;
					if (acc_cnt_q == '0) begin
						state_q <= S_RATE;
					end else begin
						dv_num_q <= {2'd0, tot_abs, 8'd0};
						dv_den_q <= acc_cnt_q;
						dv_rem_q <= '0;
						dv_cnt_q <= '0;
						state_q  <= S_AVG_W;
					end
				end
				S_AVG_W: begin
					dv_num_q <= dv_num_n;
					dv_rem_q <= dv_rem_n;
					dv_cnt_q <= dv_cnt_q + 1'b1;
					if (dv_cnt_q == wbs_pkg::DSTEP_W'(wbs_pkg::DIV_STEPS - 1)) begin
						if (acc_tot_q[47])
							avg_q <= (dv_num_n > 58'h80_0000_0000) ? wbs_pkg::AVG_MIN :
								40'(-dv_num_n);
						else
							avg_q <= (dv_num_n > 58'h7F_FFFF_FFFF) ? wbs_pkg::AVG_MAX :
								dv_num_n[39:0];
						state_q <= S_RATE;
					end
				end
				S_RATE: begin
					rate_q <= '0;
					if (cmd_q == wbs_pkg::CMD_QUERY && span_q != '0) begin
						dv_num_q <= rate_dividend;
						dv_den_q <= {8'd0, span_q};
						dv_rem_q <= '0;
						dv_cnt_q <= '0;
						state_q  <= S_RATE_W;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_RATE_W: begin
					dv_num_q <= dv_num_n;
					dv_rem_q <= dv_rem_n;
					dv_cnt_q <= dv_cnt_q + 1'b1;
					if (dv_cnt_q == wbs_pkg::DSTEP_W'(wbs_pkg::DIV_STEPS - 1)) begin
						rate_q  <= acc_tot_q[47] ? -dv_num_n : dv_num_n;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (cmd_q == wbs_pkg::CMD_QUERY) begin
						done_q  <= 1'b1;
						last_q  <= 1'b1;
						out_q   <= cur_res;
						state_q <= S_IDLE;
					end else begin
						if (pend_vld_q) begin
							done_q <= 1'b1;
							last_q <= 1'b0;
							out_q  <= pend_q;
						end
						pend_q     <= cur_res;
						pend_vld_q <= 1'b1;
						k_q        <= k_q + 1'b1;
						state_q    <= S_D_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* tb/sv/windowed_bucket_stats_top_test.sv */
// Self-checking testbench for windowed_bucket_stats_top.
// Depends on wbs_pkg and the block's RTL; it carries its own model of the bucket ring.
`timescale 1ns / 1ps

module windowed_bucket_stats_top_test;

	// Command code that the block must ignore.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// Byte addresses of the two configuration registers.
	localparam logic [2:0] ADDR_WINDOW = 3'd0;
	localparam logic [2:0] ADDR_BUCKET = 3'd4;
	// Cycles with no transfer before the run is declared hung. The slowest
	// legal wait is a full dump of 16 buckets plus the longest sender gap,
	// so this leaves a wide margin.
	localparam int STALL_LIMIT = 20000;
	// Quiet time after the last result; covers an add that retires the whole ring.
	localparam int DRAIN_CYCLES = 200;

	// One result transfer as seen on the output ports.
	typedef struct packed {
		logic signed [31:0] mn;
		logic signed [31:0] mx;
		logic signed [47:0] tot;
		logic [23:0]        cnt;
		logic signed [39:0] avg;
		logic signed [57:0] rate;
		logic               fin;
	} stat_rec_t;

	// One row of the directed stimulus table. When zero_result is set the
	// expected transfer is typed in as the all-zero record with last high.
	typedef struct {
		logic [1:0]         op;
		logic [31:0]        now;
		logic signed [31:0] val;
		logic [15:0]        span;
		bit                 zero_result;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         cmd = '0;
	logic [31:0]        now_ms = '0;
	logic signed [31:0] sample = '0;
	logic [15:0]        span_ms = '0;
	logic               done;
	logic signed [31:0] min_value;
	logic signed [31:0] max_value;
	logic signed [47:0] total;
	logic [23:0]        sample_count;
	logic signed [39:0] average_q8;
	logic signed [57:0] rate_per_second;
	logic               last;

	windowed_bucket_stats_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.cmd(cmd), .now_ms(now_ms), .sample(sample), .span_ms(span_ms),
		.done(done), .min_value(min_value), .max_value(max_value), .total(total),
		.sample_count(sample_count), .average_q8(average_q8),
		.rate_per_second(rate_per_second), .last(last)
	);

	always #1 clk = ~clk;

	// Model state: the bucket ring and the two registers.
	logic [31:0]        ring_start [wbs_pkg::MAX_BUCKETS];
	longint             ring_total [wbs_pkg::MAX_BUCKETS];
	int unsigned        ring_count [wbs_pkg::MAX_BUCKETS];
	logic signed [31:0] ring_min   [wbs_pkg::MAX_BUCKETS];
	logic signed [31:0] ring_max   [wbs_pkg::MAX_BUCKETS];
	int unsigned        oldest_pos = 0;
	int unsigned        live_count = 0;
	logic [31:0]        window_len = 32'(wbs_pkg::WINDOW_RESET);
	logic [31:0]        bucket_len = 32'(wbs_pkg::BUCKET_RESET);

	stat_rec_t pending_stats[$];
	bit        failed = 1'b0;
	int        stall_cycles = 0;

	// Appends one expected result at the tail of the queue.
	function automatic void queue_stats(stat_rec_t r);
		pending_stats = {pending_stats, r};
	endfunction

	function automatic longint clamp_total(longint a, longint b);
		longint s;
		s = a + b;
		if (s > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
		if (s < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
		return s;
	endfunction

	function automatic int unsigned clamp_count(int unsigned a, int unsigned b);
		longint unsigned s;
		s = longint'(a) + longint'(b);
		return (s > 64'(wbs_pkg::CNT_MAX)) ? int'(wbs_pkg::CNT_MAX) : int'(s);
	endfunction

	// Builds a result record; the average is the Q8 quotient, clamped to 40 bits.
	function automatic stat_rec_t stats_record(logic signed [31:0] mn, logic signed [31:0] mx,
			longint tot, int unsigned cnt, longint rate, bit fin);
		stat_rec_t r;
		longint avg;
		avg = 0;
		if (cnt != 0) begin
			avg = (tot * 256) / longint'(cnt);
			if (avg > 64'sh7F_FFFF_FFFF) avg = 64'sh7F_FFFF_FFFF;
			if (avg < -64'sh80_0000_0000) avg = -64'sh80_0000_0000;
		end
		r.mn = mn;
		r.mx = mx;
		r.tot = tot[47:0];
		r.cnt = cnt[23:0];
		r.avg = avg[39:0];
		r.rate = rate[57:0];
		r.fin = fin;
		return r;
	endfunction

	// Updates the model for one accepted command and queues what it must produce.
	task automatic predict_stats(logic [1:0] op, logic [31:0] now, logic signed [31:0] v,
			logic [15:0] span_in);
		int unsigned n;
		int unsigned k;
		int unsigned cnt;
		int          nres;
		logic [31:0] span;
		logic signed [31:0] mn;
		logic signed [31:0] mx;
		longint      tot;
		longint      rate;
		bit          any;
		case (op)
			wbs_pkg::CMD_ADD: begin
				while (live_count > 0 && (now - ring_start[oldest_pos]) > window_len) begin
					oldest_pos = (oldest_pos + 1) % wbs_pkg::MAX_BUCKETS;
					live_count--;
				end
				n = (oldest_pos + live_count - 1) % wbs_pkg::MAX_BUCKETS;
				if (live_count > 0 && (now - ring_start[n]) < bucket_len) begin
					ring_total[n] = clamp_total(ring_total[n], longint'(v));
					ring_count[n] = clamp_count(ring_count[n], 1);
					if (v < ring_min[n]) ring_min[n] = v;
					if (v > ring_max[n]) ring_max[n] = v;
				end else begin
					// A full ring drops its oldest bucket to make room.
					if (live_count >= wbs_pkg::MAX_BUCKETS) begin
						n = oldest_pos;
						oldest_pos = (oldest_pos + 1) % wbs_pkg::MAX_BUCKETS;
					end else begin
						n = (oldest_pos + live_count) % wbs_pkg::MAX_BUCKETS;
						live_count++;
					end
					ring_start[n] = now;
					ring_total[n] = longint'(v);
					ring_count[n] = 1;
					ring_min[n] = v;
					ring_max[n] = v;
				end
			end
			wbs_pkg::CMD_QUERY: begin
				span = {16'd0, span_in};
				if (span > window_len) span = window_len;
				mn = 0;
				mx = 0;
				tot = 0;
				cnt = 0;
				rate = 0;
				any = 1'b0;
				// Walk from the newest bucket and stop at the first one too old.
				for (k = live_count; k > 0; k--) begin
					n = (oldest_pos + k - 1) % wbs_pkg::MAX_BUCKETS;
					if ((now - ring_start[n]) > span) break;
					if (!any || ring_min[n] < mn) mn = ring_min[n];
					if (!any || ring_max[n] > mx) mx = ring_max[n];
					any = 1'b1;
					tot = clamp_total(tot, ring_total[n]);
					cnt = clamp_count(cnt, ring_count[n]);
				end
				if (span != 0) rate = (tot * 1000) / longint'(span);
				queue_stats(stats_record(mn, mx, tot, cnt, rate, 1'b1));
			end
			wbs_pkg::CMD_DUMP: begin
				nres = 0;
				for (k = 0; k < live_count; k++) begin
					n = (oldest_pos + k) % wbs_pkg::MAX_BUCKETS;
					if ((now - ring_start[n]) > window_len) continue;
					queue_stats(stats_record(ring_min[n], ring_max[n],
						ring_total[n], ring_count[n], 0, 1'b0));
					nres++;
				end
				if (nres == 0) begin
					queue_stats(stats_record(0, 0, 0, 0, 0, 1'b1));
				end else begin
					pending_stats[pending_stats.size() - 1].fin = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endtask

	// Presents one command after a gap and waits until the block takes it. start is
	// left high so that a following command with no gap keeps it high.
	task automatic issue_cmd(logic [1:0] op, logic [31:0] now, logic signed [31:0] v,
			logic [15:0] span, int gap, bit zero_result);
		bit taken;
		repeat (gap) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start = 1'b1;
		cmd = op;
		now_ms = now;
		sample = v;
		span_ms = span;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		if (zero_result) begin
			queue_stats(stats_record(0, 0, 0, 0, 0, 1'b1));
		end else begin
			predict_stats(op, now, v, span);
		end
	endtask

	// Waits until every expected result has come, then lets a late add finish.
	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Two-phase register write: setup cycle, then the access cycle.
	task automatic write_reg(logic [2:0] addr, logic [15:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = {16'd0, value};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (addr == ADDR_WINDOW) window_len = {16'd0, value};
		else bucket_len = {16'd0, value};
	endtask

	// Mostly back-to-back or short gaps, with the odd long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) return 0;
		if (roll < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic signed [31:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $urandom_range(0, 200) - 100;
			default: return $urandom;
		endcase
	endfunction

	// Result checker: every done cycle must match the oldest expectation.
	always @(posedge clk) begin
		stat_rec_t got;
		stat_rec_t want;
		if (arst_n && done) begin
			got = '{min_value, max_value, total, sample_count, average_q8,
				rate_per_second, last};
			if (pending_stats.size() == 0) begin
				$display("%0t: result with nothing expected: min=%0d max=%0d total=%0d",
					$realtime, min_value, max_value, total);
				failed = 1'b1;
			end else begin
				want = pending_stats[0];
				pending_stats.delete(0);
				if (got !== want) begin
					$display("%0t: mismatch expected min=%0d max=%0d total=%0d count=%0d avg=%0d rate=%0d last=%0b",
						$realtime, want.mn, want.mx, want.tot, want.cnt, want.avg,
						want.rate, want.fin);
					$display("%0t:          actual   min=%0d max=%0d total=%0d count=%0d avg=%0d rate=%0d last=%0b",
						$realtime, got.mn, got.mx, got.tot, got.cnt, got.avg,
						got.rate, got.fin);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither a command nor a result transfer
	// takes place.
	always @(posedge clk) begin
		if ((start && !busy) || done) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	stim_row_t directed [20] = '{
		// Empty ring right after reset: both query and dump give the zero record.
		'{wbs_pkg::CMD_QUERY, 32'd0,         32'sd0,         16'd0,    1'b1},
		'{wbs_pkg::CMD_DUMP,  32'd0,         32'sd0,         16'd0,    1'b1},
		// Extreme samples merge into one bucket; age equal to bucket_ms opens a new one.
		'{wbs_pkg::CMD_ADD,   32'd0,         32'sh7FFF_FFFF, 16'd0,    1'b0},
		'{wbs_pkg::CMD_ADD,   32'd5,         32'sh8000_0000, 16'd0,    1'b0},
		'{wbs_pkg::CMD_ADD,   32'd100,       32'sd0,         16'd0,    1'b0},
		'{wbs_pkg::CMD_ADD,   32'd150,       -32'sd1,        16'd0,    1'b0},
		// Zero span still counts buckets of age zero but reports no rate.
		'{wbs_pkg::CMD_QUERY, 32'd100,       32'sd0,         16'd0,    1'b0},
		'{wbs_pkg::CMD_QUERY, 32'd150,       32'sd0,         16'hFFFF, 1'b0},
		'{wbs_pkg::CMD_QUERY, 32'd150,       32'sd0,         16'd50,   1'b0},
		'{wbs_pkg::CMD_DUMP,  32'd150,       32'sd0,         16'd0,    1'b0},
		'{CMD_UNUSED,         32'd200,       32'sd7,         16'd9,    1'b0},
		'{wbs_pkg::CMD_DUMP,  32'd1101,      32'sd0,         16'd0,    1'b0},
		// Time wrap: the late timestamp retires everything, then ages wrap past zero.
		'{wbs_pkg::CMD_ADD,   32'hFFFF_FFF0, 32'sd1,         16'd0,    1'b0},
		'{wbs_pkg::CMD_ADD,   32'h0000_0010, 32'sd2,         16'd0,    1'b0},
		'{wbs_pkg::CMD_QUERY, 32'h0000_0020, 32'sd0,         16'd1000, 1'b0},
		'{wbs_pkg::CMD_DUMP,  32'h0000_0020, 32'sd0,         16'd0,    1'b0},
		'{wbs_pkg::CMD_ADD,   32'd5000,      32'sh5555_5555, 16'd0,    1'b0},
		'{wbs_pkg::CMD_ADD,   32'd5100,      32'shAAAA_AAAA, 16'd0,    1'b0},
		'{wbs_pkg::CMD_QUERY, 32'd5100,      32'sd0,         16'd100,  1'b0},
		'{wbs_pkg::CMD_DUMP,  32'd5100,      32'sd0,         16'd0,    1'b0}
	};

	initial begin
		logic [31:0] base;
		logic [15:0] win_setting [4];
		logic [15:0] bkt_setting [4];
		int          roll;
		logic [1:0]  op;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			issue_cmd(directed[i].op, directed[i].now, directed[i].val, directed[i].span,
				pick_gap(), directed[i].zero_result);
		wait_idle();

		// Register settings for the random phases, extremes included. A long
		// window with one-ms buckets overflows the ring; the opposite retires
		// almost everything and merges almost everything.
		win_setting = '{16'hFFFF, 16'd1, 16'($urandom_range(50, 3000)), 16'd1000};
		bkt_setting = '{16'd1, 16'hFFFF, 16'($urandom_range(1, 300)), 16'd100};
		base = $urandom;
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(ADDR_WINDOW, win_setting[ph]);
			write_reg(ADDR_BUCKET, bkt_setting[ph]);
			for (int i = 0; i < 32; i++) begin
				// Time mostly creeps forward; now and then it jumps anywhere.
				roll = $urandom_range(0, 99);
				if (roll < 8) base = $urandom;
				else base = base + $urandom_range(0, (ph == 2) ? 120 : 4);
				roll = $urandom_range(0, 99);
				if (roll < 55) op = wbs_pkg::CMD_ADD;
				else if (roll < 78) op = wbs_pkg::CMD_QUERY;
				else if (roll < 95) op = wbs_pkg::CMD_DUMP;
				else op = CMD_UNUSED;
				issue_cmd(op, base, pick_sample(),
					($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64)),
					pick_gap(), 1'b0);
			end
			wait_idle();
		end

		if (!failed) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
